>>> rtl/core/nrsh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrsh_pkg: shared types and constants of the nearest ray-sphere hit core
// Widths of the fixed point values, datapath command codes, multiply operand
// selections and the command and status records between the controller and
// the datapath.
// ----------------------------------------------------------------------------
package nrsh_pkg;

    // Fixed point format and table size.
    localparam int FRAC_BITS   = 16;
    localparam int MAX_SPHERES = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int MIN_W       = 16;

    // Field widths.
    localparam int COORD_W = 40;
    localparam int RAD_W   = 39;
    localparam int DIR_W   = 18;
    localparam int DIST_W  = 39;

    // Internal widths.
    localparam int OC_W     = COORD_W + 1;            // center minus origin
    localparam int DOT_W    = OC_W + DIR_W + 2;       // sum of three products
    localparam int B_W      = DOT_W - FRAC_BITS;      // projection b
    localparam int MAG_W    = B_W;                    // widest multiplier operand
    localparam int ACC_W    = 96;                     // accumulator, holds disc
    localparam int ROOT_W   = ACC_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQ_CNT_W = 6;
    localparam int T_W      = ROOT_W + 2;             // root sums, signed

    // Datapath commands.
    typedef logic [3:0] dp_op_t;
    localparam dp_op_t DP_NOP     = 4'd0;
    localparam dp_op_t DP_LOAD    = 4'd1;
    localparam dp_op_t DP_CAPTURE = 4'd2;
    localparam dp_op_t DP_READ    = 4'd3;
    localparam dp_op_t DP_OC      = 4'd4;
    localparam dp_op_t DP_MSET    = 4'd5;
    localparam dp_op_t DP_MSTEP   = 4'd6;
    localparam dp_op_t DP_TAKE_B  = 4'd7;
    localparam dp_op_t DP_SQ_INIT = 4'd8;
    localparam dp_op_t DP_SQ_STEP = 4'd9;
    localparam dp_op_t DP_CHECK   = 4'd10;
    localparam dp_op_t DP_UPDATE  = 4'd11;

    // Multiply operand selections, in the order the controller runs them.
    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MS_OX_DX = 3'd0;
    localparam mul_sel_t MS_OY_DY = 3'd1;
    localparam mul_sel_t MS_OZ_DZ = 3'd2;
    localparam mul_sel_t MS_B_B   = 3'd3;
    localparam mul_sel_t MS_R_R   = 3'd4;
    localparam mul_sel_t MS_OX_OX = 3'd5;
    localparam mul_sel_t MS_OY_OY = 3'd6;
    localparam mul_sel_t MS_OZ_OZ = 3'd7;

    typedef struct packed {
        dp_op_t           op;
        mul_sel_t         sel;
        logic [IDX_W-1:0] index;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic disc_neg;
        logic sq_last;
    } dp_status_t;

    // One input item without its opcode.
    typedef struct packed {
        logic [DIR_W-1:0]   ray_dz;
        logic [DIR_W-1:0]   ray_dy;
        logic [DIR_W-1:0]   ray_dx;
        logic [COORD_W-1:0] ray_oz;
        logic [COORD_W-1:0] ray_oy;
        logic [COORD_W-1:0] ray_ox;
        logic [COORD_W-1:0] sphere_cz;
        logic [COORD_W-1:0] sphere_cy;
        logic [COORD_W-1:0] sphere_cx;
        logic [RAD_W-1:0]   sphere_radius_in;
        logic [IDX_W-1:0]   entry_index;
    } item_t;

endpackage
`default_nettype wire

>>> rtl/core/nrsh_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrsh_dpath: datapath of the nearest ray-sphere hit core
// Sphere tables, a shift-add multiply-accumulate unit, a restoring square
// root unit and the nearest hit tracking, all run by commands.
// ----------------------------------------------------------------------------
module nrsh_dpath (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  nrsh_pkg::dp_cmd_t              cmd,
    input  nrsh_pkg::item_t                item,
    input  wire  [nrsh_pkg::MIN_W-1:0]     min_distance,
    output nrsh_pkg::dp_status_t           status,
    output logic                           res_hit,
    output logic [nrsh_pkg::DIST_W-1:0]    res_distance,
    output logic [nrsh_pkg::IDX_W-1:0]     res_index
);

    localparam int OC_W   = nrsh_pkg::OC_W;
    localparam int MAG_W  = nrsh_pkg::MAG_W;
    localparam int ACC_W  = nrsh_pkg::ACC_W;
    localparam int ROOT_W = nrsh_pkg::ROOT_W;
    localparam int REM_W  = nrsh_pkg::REM_W;
    localparam int T_W    = nrsh_pkg::T_W;
    localparam int B_W    = nrsh_pkg::B_W;

    // Sphere tables.
    logic [nrsh_pkg::RAD_W-1:0]   radius_mem [nrsh_pkg::MAX_SPHERES];
    logic [nrsh_pkg::COORD_W-1:0] cx_mem     [nrsh_pkg::MAX_SPHERES];
    logic [nrsh_pkg::COORD_W-1:0] cy_mem     [nrsh_pkg::MAX_SPHERES];
    logic [nrsh_pkg::COORD_W-1:0] cz_mem     [nrsh_pkg::MAX_SPHERES];

    logic [nrsh_pkg::RAD_W-1:0]   rd_r_reg;
    logic [nrsh_pkg::COORD_W-1:0] rd_cx_reg, rd_cy_reg, rd_cz_reg;

    // Ray and per-sphere values.
    logic signed [nrsh_pkg::COORD_W-1:0] ray_ox_reg, ray_oy_reg, ray_oz_reg;
    logic signed [nrsh_pkg::DIR_W-1:0]   ray_dx_reg, ray_dy_reg, ray_dz_reg;
    logic signed [OC_W-1:0]              ox_reg, oy_reg, oz_reg;
    logic signed [B_W-1:0]               b_reg;

    // Multiply-accumulate unit.
    logic signed [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0]        mcand_reg;
    logic [MAG_W-1:0]        mplier_reg;
    logic                    msub_reg;

    // Square root unit.
    logic [ROOT_W-1:0]             root_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [nrsh_pkg::SQ_CNT_W-1:0] sq_cnt_reg;

    // Hit tracking.
    logic                        cand_ok_reg;
    logic signed [T_W-1:0]       cand_reg;
    logic                        found_reg;
    logic signed [T_W-1:0]       best_reg;
    logic [nrsh_pkg::IDX_W-1:0]  best_idx_reg;

    logic [REM_W-1:0]      rem_shift;
    logic [REM_W-1:0]      trial;
    logic signed [T_W-1:0] t_near, t_far, min_ext;

    function automatic logic [MAG_W-1:0] mag_oc(input logic [OC_W-1:0] v);
        logic [OC_W-1:0] u;
        u = v[OC_W-1] ? (~v + 1'b1) : v;
        return {{(MAG_W-OC_W){1'b0}}, u};
    endfunction

    function automatic logic [MAG_W-1:0] mag_dir(input logic [nrsh_pkg::DIR_W-1:0] v);
        logic [nrsh_pkg::DIR_W-1:0] u;
        u = v[nrsh_pkg::DIR_W-1] ? (~v + 1'b1) : v;
        return {{(MAG_W-nrsh_pkg::DIR_W){1'b0}}, u};
    endfunction

    function automatic logic [MAG_W-1:0] mag_b(input logic [B_W-1:0] v);
        return v[B_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Table writes and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.op == nrsh_pkg::DP_LOAD) begin
            radius_mem[item.entry_index] <= item.sphere_radius_in;
            cx_mem[item.entry_index]     <= item.sphere_cx;
            cy_mem[item.entry_index]     <= item.sphere_cy;
            cz_mem[item.entry_index]     <= item.sphere_cz;
        end
        if (cmd.op == nrsh_pkg::DP_READ) begin
            rd_r_reg  <= radius_mem[cmd.index];
            rd_cx_reg <= cx_mem[cmd.index];
            rd_cy_reg <= cy_mem[cmd.index];
            rd_cz_reg <= cz_mem[cmd.index];
        end
    end

    // Square root step and root candidates.
    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], acc_reg[ACC_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        t_near    = T_W'(b_reg) - $signed({2'b00, root_reg});
        t_far     = T_W'(b_reg) + $signed({2'b00, root_reg});
        min_ext   = $signed({{(T_W-nrsh_pkg::MIN_W){1'b0}}, min_distance});
    end

    // Payload registers of the arithmetic.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            nrsh_pkg::DP_CAPTURE: begin
                ray_ox_reg <= item.ray_ox;
                ray_oy_reg <= item.ray_oy;
                ray_oz_reg <= item.ray_oz;
                ray_dx_reg <= item.ray_dx;
                ray_dy_reg <= item.ray_dy;
                ray_dz_reg <= item.ray_dz;
            end
            nrsh_pkg::DP_OC: begin
                ox_reg  <= OC_W'($signed(rd_cx_reg)) - OC_W'(ray_ox_reg);
                oy_reg  <= OC_W'($signed(rd_cy_reg)) - OC_W'(ray_oy_reg);
                oz_reg  <= OC_W'($signed(rd_cz_reg)) - OC_W'(ray_oz_reg);
                acc_reg <= '0;
            end
            nrsh_pkg::DP_MSET: begin
                case (cmd.sel)
                    nrsh_pkg::MS_OX_DX: begin
                        mcand_reg  <= ACC_W'(mag_oc(ox_reg));
                        mplier_reg <= mag_dir(ray_dx_reg);
                        msub_reg   <= ox_reg[OC_W-1] ^ ray_dx_reg[nrsh_pkg::DIR_W-1];
                    end
                    nrsh_pkg::MS_OY_DY: begin
                        mcand_reg  <= ACC_W'(mag_oc(oy_reg));
                        mplier_reg <= mag_dir(ray_dy_reg);
                        msub_reg   <= oy_reg[OC_W-1] ^ ray_dy_reg[nrsh_pkg::DIR_W-1];
                    end
                    nrsh_pkg::MS_OZ_DZ: begin
                        mcand_reg  <= ACC_W'(mag_oc(oz_reg));
                        mplier_reg <= mag_dir(ray_dz_reg);
                        msub_reg   <= oz_reg[OC_W-1] ^ ray_dz_reg[nrsh_pkg::DIR_W-1];
                    end
                    nrsh_pkg::MS_B_B: begin
                        mcand_reg  <= ACC_W'(mag_b(b_reg));
                        mplier_reg <= mag_b(b_reg);
                        msub_reg   <= 1'b0;
                    end
                    nrsh_pkg::MS_R_R: begin
                        mcand_reg  <= ACC_W'(rd_r_reg);
                        mplier_reg <= MAG_W'(rd_r_reg);
                        msub_reg   <= 1'b0;
                    end
                    nrsh_pkg::MS_OX_OX: begin
                        mcand_reg  <= ACC_W'(mag_oc(ox_reg));
                        mplier_reg <= mag_oc(ox_reg);
                        msub_reg   <= 1'b1;
                    end
                    nrsh_pkg::MS_OY_OY: begin
                        mcand_reg  <= ACC_W'(mag_oc(oy_reg));
                        mplier_reg <= mag_oc(oy_reg);
                        msub_reg   <= 1'b1;
                    end
                    default: begin
                        mcand_reg  <= ACC_W'(mag_oc(oz_reg));
                        mplier_reg <= mag_oc(oz_reg);
                        msub_reg   <= 1'b1;
                    end
                endcase
            end
            nrsh_pkg::DP_MSTEP: begin
                // One multiplier bit per cycle into the accumulator.
                if (mplier_reg[0]) begin
                    acc_reg <= msub_reg ? acc_reg - $signed(mcand_reg)
                                        : acc_reg + $signed(mcand_reg);
                end
                mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[MAG_W-1:1]};
            end
            nrsh_pkg::DP_TAKE_B: begin
                // Dropping the fraction bits of a two's complement sum floors it.
                b_reg   <= acc_reg[nrsh_pkg::DOT_W-1:nrsh_pkg::FRAC_BITS];
                acc_reg <= '0;
            end
            nrsh_pkg::DP_SQ_INIT: begin
                root_reg   <= '0;
                rem_reg    <= '0;
                sq_cnt_reg <= nrsh_pkg::SQ_CNT_W'(ROOT_W - 1);
            end
            nrsh_pkg::DP_SQ_STEP: begin
                // One root bit per cycle from the top two bits of the radicand.
                if (rem_shift >= trial) begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                acc_reg    <= {acc_reg[ACC_W-3:0], 2'b00};
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
            end
            nrsh_pkg::DP_CHECK: begin
                // The near root wins when it clears the minimum, else the far one.
                cand_ok_reg <= (t_near > min_ext) || (t_far > min_ext);
                cand_reg    <= (t_near > min_ext) ? t_near : t_far;
            end
            default: begin
            end
        endcase
    end

    // Nearest hit so far; a strictly smaller distance replaces it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.op == nrsh_pkg::DP_CAPTURE || cmd.op == nrsh_pkg::DP_LOAD) begin
            found_reg <= 1'b0;
        end else if (cmd.op == nrsh_pkg::DP_UPDATE && cand_ok_reg &&
                     (!found_reg || cand_reg < best_reg)) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == nrsh_pkg::DP_UPDATE && cand_ok_reg &&
            (!found_reg || cand_reg < best_reg)) begin
            best_reg     <= cand_reg;
            best_idx_reg <= cmd.index;
        end
    end

    // Status to the controller.
    always_comb begin
        status.mul_done = (mplier_reg == '0);
        status.disc_neg = acc_reg[ACC_W-1];
        status.sq_last  = (sq_cnt_reg == '0);
    end

    // Result fields, distance saturated.
    always_comb begin
        res_hit      = found_reg;
        res_distance = '0;
        res_index    = '0;
        if (found_reg) begin
            res_index = best_idx_reg;
            if (best_reg[T_W-1:nrsh_pkg::DIST_W] != '0) begin
                res_distance = '1;
            end else begin
                res_distance = best_reg[nrsh_pkg::DIST_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/nrsh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrsh_ctrl: controller of the nearest ray-sphere hit core
// Sequences loads and ray traces over the sphere table, from the highest
// searched slot down, and hands finished results to the output register.
// ----------------------------------------------------------------------------
module nrsh_ctrl (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_accept,
    input  wire                            in_opcode,
    input  wire  [nrsh_pkg::CNT_W-1:0]     sphere_count,
    input  nrsh_pkg::dp_status_t           status,
    input  wire                            out_free,
    output logic                           in_ready,
    output logic                           out_load,
    output nrsh_pkg::dp_cmd_t              cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_OC     = 4'd2;
    localparam logic [3:0] S_MSET   = 4'd3;
    localparam logic [3:0] S_MRUN   = 4'd4;
    localparam logic [3:0] S_TAKEB  = 4'd5;
    localparam logic [3:0] S_SQINIT = 4'd6;
    localparam logic [3:0] S_SQRUN  = 4'd7;
    localparam logic [3:0] S_CHECK  = 4'd8;
    localparam logic [3:0] S_UPDATE = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    logic [3:0]                 state_reg, state_next;
    logic [nrsh_pkg::CNT_W-1:0] left_reg, left_next;
    nrsh_pkg::mul_sel_t         sel_reg, sel_next;
    logic [nrsh_pkg::CNT_W-1:0] count_lim;

    always_comb begin
        count_lim = (sphere_count > nrsh_pkg::CNT_W'(nrsh_pkg::MAX_SPHERES))
                  ? nrsh_pkg::CNT_W'(nrsh_pkg::MAX_SPHERES) : sphere_count;
    end

    // Next state and datapath command.
    always_comb begin
        state_next = state_reg;
        left_next  = left_reg;
        sel_next   = sel_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        cmd.op     = nrsh_pkg::DP_NOP;
        cmd.sel    = sel_reg;
        cmd.index  = nrsh_pkg::IDX_W'(left_reg - 1'b1);
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    if (in_opcode) begin
                        cmd.op     = nrsh_pkg::DP_LOAD;
                        state_next = S_FINISH;
                    end else begin
                        cmd.op     = nrsh_pkg::DP_CAPTURE;
                        left_next  = count_lim;
                        state_next = (count_lim == '0) ? S_FINISH : S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.op     = nrsh_pkg::DP_READ;
                state_next = S_OC;
            end
            S_OC: begin
                cmd.op     = nrsh_pkg::DP_OC;
                sel_next   = nrsh_pkg::MS_OX_DX;
                state_next = S_MSET;
            end
            S_MSET: begin
                cmd.op     = nrsh_pkg::DP_MSET;
                state_next = S_MRUN;
            end
            S_MRUN: begin
                if (status.mul_done) begin
                    if (sel_reg == nrsh_pkg::MS_OZ_DZ) begin
                        state_next = S_TAKEB;
                    end else if (sel_reg == nrsh_pkg::MS_OZ_OZ) begin
                        state_next = S_SQINIT;
                    end else begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_MSET;
                    end
                end else begin
                    cmd.op = nrsh_pkg::DP_MSTEP;
                end
            end
            S_TAKEB: begin
                cmd.op     = nrsh_pkg::DP_TAKE_B;
                sel_next   = nrsh_pkg::MS_B_B;
                state_next = S_MSET;
            end
            S_SQINIT: begin
                // A negative discriminant misses this sphere.
                if (status.disc_neg) begin
                    left_next  = left_reg - 1'b1;
                    state_next = (left_reg == 5'd1) ? S_FINISH : S_READ;
                end else begin
                    cmd.op     = nrsh_pkg::DP_SQ_INIT;
                    state_next = S_SQRUN;
                end
            end
            S_SQRUN: begin
                cmd.op = nrsh_pkg::DP_SQ_STEP;
                if (status.sq_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.op     = nrsh_pkg::DP_CHECK;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.op     = nrsh_pkg::DP_UPDATE;
                left_next  = left_reg - 1'b1;
                state_next = (left_reg == 5'd1) ? S_FINISH : S_READ;
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            left_reg  <= '0;
            sel_reg   <= nrsh_pkg::MS_OX_DX;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
            sel_reg   <= sel_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/nearest_ray_sphere_hit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_ray_sphere_hit_core: nearest ray-sphere hit search
// Loads sphere entries into a 16-slot table and answers ray traces with the
// nearest hit distance and slot, in Q23.16 fixed point.
//
//   Channel   Direction   Moves
//   s_*       in          one load or trace request per item
//   m_*       out         one result item per request
//   cfg_*     in          register writes, no read-back
//
// A trace runs, per searched sphere, eight bit-serial multiplies on one
// shared shift-add accumulator (one multiplier bit per cycle, stopping when
// the remaining multiplier is zero) and, unless the discriminant is negative,
// a 48-step restoring square root.
// A new item is taken once the previous result has been placed in the output
// register; that register holds while m_tready is low. Reset is synchronous
// and resets the control, config and valid registers, not the sphere table.
// ----------------------------------------------------------------------------
module nearest_ray_sphere_hit_core (
    input  wire         aclk,
    input  wire         aresetn,
    // Input items.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [0:0]  s_tuser,    // opcode
    input  wire  [343:0] s_tdata,   // entry_index, sphere_radius_in, sphere_cx,
                                    // sphere_cy, sphere_cz, ray_ox, ray_oy,
                                    // ray_oz, ray_dx, ray_dy, ray_dz, zero pad
    // Result items.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [0:0]  m_tuser,    // hit
    output logic [47:0] m_tdata,    // hit_distance, hit_index, zero pad
    // Configuration writes.
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_addr,
    input  wire  [15:0] cfg_wdata
);

    localparam logic [1:0] REG_SPHERE_COUNT = 2'd0;
    localparam logic [1:0] REG_MIN_DISTANCE = 2'd1;

    logic [nrsh_pkg::CNT_W-1:0] sphere_count_reg;
    logic [nrsh_pkg::MIN_W-1:0] min_distance_reg;

    nrsh_pkg::item_t      item;
    nrsh_pkg::dp_cmd_t    cmd;
    nrsh_pkg::dp_status_t status;
    logic                         in_ready, in_accept, out_load, out_free;
    logic                         res_hit;
    logic [nrsh_pkg::DIST_W-1:0]  res_distance;
    logic [nrsh_pkg::IDX_W-1:0]   res_index;

    logic        m_tvalid_reg;
    logic [0:0]  m_tuser_reg;
    logic [47:0] m_tdata_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sphere_count_reg <= '0;
            min_distance_reg <= nrsh_pkg::MIN_W'(7);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SPHERE_COUNT: sphere_count_reg <= cfg_wdata[nrsh_pkg::CNT_W-1:0];
                REG_MIN_DISTANCE: min_distance_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input unpacking.
    assign item      = s_tdata[$bits(nrsh_pkg::item_t)-1:0];
    assign s_tready  = in_ready;
    assign in_accept = s_tvalid && in_ready;
    assign out_free  = !m_tvalid_reg || m_tready;

    nrsh_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_opcode    (s_tuser[0]),
        .sphere_count (sphere_count_reg),
        .status       (status),
        .out_free     (out_free),
        .in_ready     (in_ready),
        .out_load     (out_load),
        .cmd          (cmd)
    );

    nrsh_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .item         (item),
        .min_distance (min_distance_reg),
        .status       (status),
        .res_hit      (res_hit),
        .res_distance (res_distance),
        .res_index    (res_index)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_hit;
            m_tdata_reg <= {5'd0, res_index, res_distance};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

>>> rtl/core/nrsh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrsh_checker: port checks of the nearest ray-sphere hit core
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module nrsh_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [0:0]  m_tuser,
    input wire [47:0] m_tdata
);

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // A miss or load acknowledge carries zero distance and slot.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 48'd0)
        else $error("result without a hit has nonzero fields");

    // One item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after an accept");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind nearest_ray_sphere_hit_core nrsh_checker u_nrsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> tb/nearest_ray_sphere_hit_core_test.sv
// ----------------------------------------------------------------------------
// nearest_ray_sphere_hit_core_test: self-checking bench of the hit search core
// Loads sphere entries and traces rays through the stream ports. Each accepted
// item is run through a bit-exact predictor of the table search. Results are
// checked in order, while sender and receiver idle at random. The bench also
// runs through several register settings, including the extremes.
// ----------------------------------------------------------------------------
module nearest_ray_sphere_hit_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = nrsh_pkg::FRAC_BITS;
    localparam int MAX_SPHERES = nrsh_pkg::MAX_SPHERES;
    localparam int IDX_W       = nrsh_pkg::IDX_W;
    localparam int CNT_W       = nrsh_pkg::CNT_W;
    localparam int MIN_W       = nrsh_pkg::MIN_W;
    localparam int COORD_W     = nrsh_pkg::COORD_W;
    localparam int RAD_W       = nrsh_pkg::RAD_W;
    localparam int DIR_W       = nrsh_pkg::DIR_W;
    localparam int DIST_W      = nrsh_pkg::DIST_W;

    typedef nrsh_pkg::item_t item_t;

    localparam int QUIET_LIMIT = 200000;
    localparam int HOLD_CYCLES = 4000;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic OP_TRACE = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic [1:0] REG_SPHERE_COUNT = 2'd0;
    localparam logic [1:0] REG_MIN_DISTANCE = 2'd1;
    localparam logic [1:0] REG_SPARE_A      = 2'd2;
    localparam logic [1:0] REG_SPARE_B      = 2'd3;

    typedef struct {
        logic  op;
        item_t f;
    } request_t;

    typedef struct {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } hit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [0:0] s_tuser = '0;
    logic [343:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [0:0] m_tuser;
    logic [47:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    nearest_ray_sphere_hit_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Predictor copy of the sphere table and the registers.
    logic [RAD_W-1:0]          radius_tab[MAX_SPHERES];
    logic signed [COORD_W-1:0] center_x_tab[MAX_SPHERES];
    logic signed [COORD_W-1:0] center_y_tab[MAX_SPHERES];
    logic signed [COORD_W-1:0] center_z_tab[MAX_SPHERES];
    logic [CNT_W-1:0] searched_count = '0;
    logic [MIN_W-1:0] min_dist = 16'd7;

    request_t request_q[$];
    hit_t     hit_q[$];
    request_t on_bus;
    int issued = 0;
    int accepted = 0;
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    int quiet = 0;

    // Nearest hit over the searched slots, highest slot first, ties keep the
    // higher slot.
    function automatic hit_t nearest_hit(item_t it);
        hit_t r;
        logic signed [127:0] ocx, ocy, ocz, dot, b, pos, neg, t, best, md;
        logic [127:0] disc, root, cand;
        int n;
        bit found, hit_k;
        r = '{1'b0, '0, '0};
        found = 1'b0;
        best = 0;
        md = $signed({112'd0, min_dist});
        n = (searched_count > MAX_SPHERES) ? MAX_SPHERES : int'(searched_count);
        for (int i = n - 1; i >= 0; i--) begin
            ocx = center_x_tab[i] - $signed(it.ray_ox);
            ocy = center_y_tab[i] - $signed(it.ray_oy);
            ocz = center_z_tab[i] - $signed(it.ray_oz);
            dot = ocx * $signed(it.ray_dx) + ocy * $signed(it.ray_dy)
                + ocz * $signed(it.ray_dz);
            b = dot >>> FRAC_BITS;
            pos = b * b + $signed({89'd0, radius_tab[i]}) * $signed({89'd0, radius_tab[i]});
            neg = ocx * ocx + ocy * ocy + ocz * ocz;
            hit_k = 1'b0;
            if (neg <= pos) begin
                disc = pos - neg;
                root = '0;
                for (int k = 63; k >= 0; k--) begin
                    cand = root | (128'd1 << k);
                    if (cand * cand <= disc) root = cand;
                end
                t = b - $signed(root);
                if (t > md) begin
                    hit_k = 1'b1;
                end else begin
                    t = b + $signed(root);
                    hit_k = (t > md);
                end
            end
            if (hit_k && (!found || t < best)) begin
                found = 1'b1;
                best = t;
                r.idx = i[IDX_W-1:0];
            end
        end
        if (found) begin
            r.hit = 1'b1;
            r.distance = (best > $signed({89'd0, DIST_MAX})) ? DIST_MAX : best[DIST_W-1:0];
        end
        return r;
    endfunction

    // A load writes the table and is acknowledged with an all-zero result.
    function automatic hit_t apply_request(request_t rq);
        hit_t r;
        r = '{1'b0, '0, '0};
        if (rq.op == OP_LOAD) begin
            radius_tab[rq.f.entry_index]   = rq.f.sphere_radius_in;
            center_x_tab[rq.f.entry_index] = rq.f.sphere_cx;
            center_y_tab[rq.f.entry_index] = rq.f.sphere_cy;
            center_z_tab[rq.f.entry_index] = rq.f.sphere_cz;
        end else begin
            r = nearest_hit(rq.f);
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] near_val(int span);
        longint v;
        v = longint'($urandom_range(0, 2 * span)) - span;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [DIR_W-1:0] rand_dir();
        logic [COORD_W-1:0] v;
        v = near_val(65536);
        return v[DIR_W-1:0];
    endfunction

    // Full-range fields, directions +-65536; callers overwrite what matters.
    function automatic request_t noise_request();
        request_t rq;
        rq.op = 1'($urandom_range(1));
        rq.f.entry_index = IDX_W'($urandom_range(15));
        rq.f.sphere_radius_in = RAD_W'({$urandom, $urandom});
        rq.f.sphere_cx = COORD_W'({$urandom, $urandom});
        rq.f.sphere_cy = COORD_W'({$urandom, $urandom});
        rq.f.sphere_cz = COORD_W'({$urandom, $urandom});
        rq.f.ray_ox = COORD_W'({$urandom, $urandom});
        rq.f.ray_oy = COORD_W'({$urandom, $urandom});
        rq.f.ray_oz = COORD_W'({$urandom, $urandom});
        rq.f.ray_dx = rand_dir();
        rq.f.ray_dy = rand_dir();
        rq.f.ray_dz = rand_dir();
        return rq;
    endfunction

    function automatic request_t load_req(int slot, logic [RAD_W-1:0] rad,
                                          logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                          logic [COORD_W-1:0] z);
        request_t rq;
        rq = noise_request();
        rq.op = OP_LOAD;
        rq.f.entry_index = slot[IDX_W-1:0];
        rq.f.sphere_radius_in = rad;
        rq.f.sphere_cx = x;
        rq.f.sphere_cy = y;
        rq.f.sphere_cz = z;
        return rq;
    endfunction

    function automatic request_t ray_req(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                         logic [COORD_W-1:0] z, logic [DIR_W-1:0] dx,
                                         logic [DIR_W-1:0] dy, logic [DIR_W-1:0] dz);
        request_t rq;
        rq = noise_request();
        rq.op = OP_TRACE;
        rq.f.ray_ox = x;
        rq.f.ray_oy = y;
        rq.f.ray_oz = z;
        rq.f.ray_dx = dx;
        rq.f.ray_dy = dy;
        rq.f.ray_dz = dz;
        return rq;
    endfunction

    // Mostly small spheres near the origin and rays among them, some noise.
    function automatic request_t random_request();
        request_t rq;
        int p;
        p = $urandom_range(99);
        if (p < 15) begin
            rq = noise_request();
        end else if (p < 50) begin
            rq = load_req($urandom_range(15),
                          RAD_W'($urandom_range(32'h1_0000, 32'h10_0000)),
                          near_val(1 << 21), near_val(1 << 21), near_val(1 << 21));
        end else if (p < 65) begin
            rq = ray_req(near_val(1 << 21), near_val(1 << 21), near_val(1 << 21),
                         ($urandom_range(1) ? 18'sd65536 : -18'sd65536), '0, '0);
        end else begin
            rq = ray_req(near_val(1 << 21), near_val(1 << 21), near_val(1 << 21),
                         rand_dir(), rand_dir(), rand_dir());
        end
        return rq;
    endfunction

    task automatic push_request(request_t rq);
        request_q.push_back(rq);
        issued++;
    endtask

    // Wait until every item is taken and every result is back.
    task automatic drain();
        while (!(request_q.size() == 0 && accepted == issued && hit_q.size() == 0))
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        if (addr == REG_SPHERE_COUNT) searched_count = data[CNT_W-1:0];
        else if (addr == REG_MIN_DISTANCE) min_dist = data;
    endtask

    task automatic set_regs(int count, int mind);
        drain();
        write_reg(REG_SPHERE_COUNT, 16'(count));
        write_reg(REG_MIN_DISTANCE, 16'(mind));
        cfg_wr_en <= 1'b0;
    endtask

    // Driver: predicts each accepted item and offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                hit_q.push_back(apply_request(on_bus));
                accepted++;
            end
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                on_bus = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= on_bus.op;
                s_tdata  <= {7'd0, on_bus.f};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (hit_q.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                e = hit_q.pop_front();
                if (m_tuser[0] !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[DIST_W-1:0] !== e.distance) begin
                    $error("hit_distance: expected %0h, got %0h", e.distance,
                           m_tdata[DIST_W-1:0]);
                    errors++;
                end
                if (m_tdata[DIST_W+IDX_W-1:DIST_W] !== e.idx) begin
                    $error("hit_index: expected %0d, got %0d", e.idx,
                           m_tdata[DIST_W+IDX_W-1:DIST_W]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("nearest_ray_sphere_hit_core_test NOT OK");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int counts[9] = '{2, 3, 1, 16, 0, 4, 31, 2, 3};
        int mins[9]   = '{7, 0, 65535, 300, 7, 4000, 0, 1000, 7};
        int sizes[9]  = '{130, 130, 130, 20, 60, 130, 15, 130, 130};
        int sidle[4]  = '{0, 55, 0, 31};
        int rstall[4] = '{0, 0, 55, 31};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every slot is loaded before any search reads it. Slots 14 and 15
        // are identical to exercise the tie rule; slot 13 is a huge sphere.
        write_reg(REG_SPARE_A, 16'(($urandom)));
        write_reg(REG_SPARE_B, 16'hFFFF);
        cfg_wr_en <= 1'b0;
        set_regs(16, 7);
        for (int k = 0; k < 13; k++)
            push_request(load_req(k, 39'h1_0000, 40'((10 + 5 * k) << 16), '0, '0));
        push_request(load_req(13, DIST_MAX, 40'h80_0000_0000, 40'h7F_FFFF_FFFF, '0));
        push_request(load_req(14, 39'h1_0000, 40'h5_0000, '0, '0));
        push_request(load_req(15, 39'h1_0000, 40'h5_0000, '0, '0));
        push_request(ray_req('0, '0, '0, 18'sd65536, '0, '0));
        push_request(ray_req('0, '0, '0, -18'sd65536, '0, '0));
        push_request(ray_req('0, '0, '0, '0, '0, '0));
        push_request(ray_req(40'h5_0000, '0, '0, '0, -18'sd65536, 18'sd65536));
        push_request(ray_req(40'h80_0000_0000, '0, '0, 18'sd65536, '0, '0));
        push_request(ray_req(40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF, 40'h80_0000_0000,
                             -18'sd65536, 18'sd65536, 18'sd65536));
        set_regs(31, 65535);
        push_request(ray_req('0, '0, '0, 18'sd65536, '0, '0));
        push_request(ray_req(40'h5_0000, '0, '0, 18'sd65536, '0, '0));
        set_regs(0, 0);
        push_request(ray_req('0, '0, '0, 18'sd65536, '0, '0));

        // Random phases under varying registers and idling.
        for (int ph = 0; ph < 9; ph++) begin
            set_regs(counts[ph], mins[ph]);
            send_idle  = sidle[ph % 4];
            recv_stall = rstall[ph % 4];
            if (ph == 1) hold_go = 1'b1;
            for (int k = 0; k < sizes[ph]; k++) push_request(random_request());
        end

        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("nearest_ray_sphere_hit_core_test OK");
        else
            $display("nearest_ray_sphere_hit_core_test NOT OK");
        $finish;
    end

endmodule
